// ===== rtl/dac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_pkg : shared types and codes
// Command and status codes, the word type and the control bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package dac_pkg;

    typedef logic signed [17:0] word_t;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_EXEC    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_REJECT   = 3'd1;
    localparam logic [2:0] ST_HALTED   = 3'd2;
    localparam logic [2:0] ST_DIV_ZERO = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_STOPPED  = 3'd5;
    localparam logic [2:0] ST_PC_END   = 3'd6;

    typedef struct packed {
        logic clear;
        logic accept;
        logic quick;
        logic fetch;
        logic decode;
        logic split;
        logic ld_commit;
        logic op_read;
        logic exec;
        logic div_step;
        logic acc_commit;
        logic push;
    } dac_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_load;
        logic go_fetch;
        logic to_acc;
        logic to_div;
        logic div_done;
        logic slot_free;
    } dac_sts_t;

endpackage

// ===== rtl/dac_item_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_item_if : input channel
// Carries one command word: command, load address and value.
// ----------------------------------------------------------------------------
interface dac_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [9:0]         address;
    logic signed [17:0] value;

    modport source (output valid, output cmd, output address, output value, input ready);
    modport sink   (input valid, input cmd, input address, input value, output ready);
endinterface

// ===== rtl/dac_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_result_if : result channel
// Carries one result word: status, pc, accumulator and write output.
// ----------------------------------------------------------------------------
interface dac_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [9:0]         pc;
    logic signed [17:0] acc_value;
    logic               out_valid;
    logic signed [17:0] out_value;

    modport source (output valid, output status, output pc, output acc_value,
                    output out_valid, output out_value, input ready);
    modport sink   (input valid, input status, input pc, input acc_value,
                    input out_valid, input out_value, output ready);
endinterface

// ===== rtl/dac_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_ram : generic single-clock RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dac_ram #(
    parameter int W     = 18,
    parameter int DEPTH = 1000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);
    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/dac_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_ctrl : sequencing controller
// Clears the word memory after reset, then walks each command word through fetch,
// decode, operand read, execute, divide and result hand-off as its command needs.
// ----------------------------------------------------------------------------
module dac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dac_pkg::dac_sts_t sts,
    output dac_pkg::dac_cmd_t cmd
);
    import dac_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_FETCH = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_SPLIT = 4'd5;
    localparam logic [3:0] S_LDCHK = 4'd6;
    localparam logic [3:0] S_OPRD  = 4'd7;
    localparam logic [3:0] S_EXEC  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.is_load)
                begin
                    state_next = S_MUL;
                end
                else if (sts.go_fetch)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.quick  = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.decode = 1'b1;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = sts.is_load ? S_LDCHK : S_OPRD;
            end
            S_LDCHK:
            begin
                cmd.ld_commit = 1'b1;
                state_next    = S_FIN;
            end
            S_OPRD:
            begin
                cmd.op_read = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.to_div)
                begin
                    state_next = S_DIV;
                end
                else if (sts.to_acc)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_ACC:
            begin
                cmd.acc_commit = 1'b1;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                if (sts.slot_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end
endmodule

// ===== rtl/dac_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_datapath : machine state and arithmetic
// Word memory, pc, accumulator, decimal word split, iterative divider and
// the result register.
// ----------------------------------------------------------------------------
module dac_datapath #(
    parameter int MEM_WORDS = 1000
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dac_pkg::dac_cmd_t  cmd,
    output dac_pkg::dac_sts_t  sts,
    input  logic [1:0]         item_cmd,
    input  logic [9:0]         item_address,
    input  dac_pkg::word_t     item_value,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [2:0]         res_status,
    output logic [9:0]         res_pc,
    output dac_pkg::word_t     res_acc_value,
    output logic               res_out_valid,
    output dac_pkg::word_t     res_out_value
);
    import dac_pkg::*;

    localparam int          AW      = $clog2(MEM_WORDS);
    localparam logic [9:0]  MEM_LIM = 10'(MEM_WORDS);
    // ceil(2^28 / 1000): exact quotient for any 18-bit magnitude
    localparam logic [18:0] RECIP   = 19'd268436;
    localparam logic signed [36:0] OVF_HI = 37'sd9999;
    localparam logic signed [36:0] OVF_LO = -37'sd9999;
    localparam logic [4:0]  DIV_STEPS = 5'd18;

    // architectural state
    logic [9:0]   pc_reg;
    word_t        acc_reg;
    logic         stop_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic         o_valid_reg;

    // latched item and working registers
    logic [1:0]   cmd_reg;
    logic [9:0]   addr_reg;
    word_t        val_reg;
    logic [17:0]  mag_reg;
    logic [36:0]  prod_reg;
    logic [3:0]   major_reg;
    logic [3:0]   minor_reg;
    logic [9:0]   opnd_reg;
    logic         neg_reg;
    logic signed [36:0] res_reg;
    logic         div_mode_reg;
    logic [17:0]  div_q_reg;
    logic [18:0]  div_rem_reg;
    logic [17:0]  div_d_reg;
    logic [4:0]   div_cnt_reg;
    logic         div_sa_reg;
    logic         div_sq_reg;
    logic [2:0]   pend_status_reg;
    logic         pend_wv_reg;
    word_t        pend_wval_reg;
    logic [2:0]   o_status_reg;
    logic [9:0]   o_pc_reg;
    word_t        o_acc_reg;
    logic         o_wv_reg;
    word_t        o_wval_reg;

    // memory port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    word_t         ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [17:0]   ram_rdata;

    dac_ram #(.W(18), .DEPTH(MEM_WORDS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // decode and operand helpers
    word_t        dec_src;
    logic [17:0]  dec_mag;
    logic [36:0]  prod_next;
    logic [7:0]   q1;
    logic [15:0]  maj_prod;
    logic [3:0]   major_next;
    logic [3:0]   minor_next;
    logic [9:0]   opnd_next;
    logic         pc_in;
    logic         opnd_in;
    logic         addr_in;
    logic         word_bad;
    logic [3:0]   grp;
    word_t        m_val;
    logic         div_op;
    logic [17:0]  acc_mag;
    logic [17:0]  m_mag;
    logic [18:0]  rem_sh;
    logic [18:0]  rem_diff;
    logic signed [36:0] quo_s;
    logic signed [36:0] rmd_s;
    logic signed [36:0] fin_r;
    logic         fin_ovf;
    logic [9:0]   pc_inc;

    assign pc_in   = (pc_reg < MEM_LIM);
    assign opnd_in = (opnd_reg < MEM_LIM);
    assign addr_in = (addr_reg < MEM_LIM);
    assign pc_inc  = pc_reg + 10'd1;

    assign dec_src    = (cmd_reg == CMD_LOAD) ? val_reg : word_t'(ram_rdata);
    assign dec_mag    = dec_src[17] ? (~dec_src + 18'd1) : dec_src;
    assign prod_next  = {19'd0, dec_mag} * {18'd0, RECIP};
    assign q1         = prod_reg[35:28];
    assign maj_prod   = {8'd0, q1} * 16'd205;
    assign major_next = maj_prod[14:11];
    assign minor_next = 4'(q1 - {major_next, 3'b000} - {3'b000, major_next, 1'b0});
    assign opnd_next  = 10'(mag_reg - 18'(q1) * 18'd1000);

    always_comb
    begin
        word_bad = 1'b0;
        if (neg_reg || major_reg < 4'd1 || major_reg > 4'd4)
        begin
            word_bad = 1'b1;
        end
        else if ((major_reg == 4'd1 || major_reg == 4'd2) && minor_reg > 4'd1)
        begin
            word_bad = 1'b1;
        end
        else if (major_reg == 4'd3 && minor_reg > 4'd4)
        begin
            word_bad = 1'b1;
        end
        else if (major_reg == 4'd4 && minor_reg > 4'd3)
        begin
            word_bad = 1'b1;
        end
    end

    assign grp     = neg_reg ? 4'd0 : major_reg;
    assign m_val   = opnd_in ? word_t'(ram_rdata) : '0;
    assign div_op  = (minor_reg == 4'd2) || (minor_reg == 4'd4);
    assign acc_mag = acc_reg[17] ? (~acc_reg + 18'd1) : acc_reg;
    assign m_mag   = m_val[17] ? (~m_val + 18'd1) : m_val;

    // restoring divide, one quotient bit a cycle
    assign rem_sh   = {div_rem_reg[17:0], div_q_reg[17]};
    assign rem_diff = rem_sh - {1'b0, div_d_reg};

    assign quo_s = div_sq_reg ? -$signed({19'd0, div_q_reg}) : $signed({19'd0, div_q_reg});
    assign rmd_s = div_sa_reg ? -$signed({18'd0, div_rem_reg}) : $signed({18'd0, div_rem_reg});
    assign fin_r = div_mode_reg ? ((minor_reg == 4'd2) ? quo_s : rmd_s) : res_reg;
    assign fin_ovf = (fin_r >= OVF_HI) || (fin_r <= OVF_LO);

    // memory port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = opnd_reg[AW-1:0];
        ram_wdata = val_reg;
        ram_re    = 1'b0;
        ram_raddr = opnd_reg[AW-1:0];
        if (cmd.clear)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (cmd.ld_commit)
        begin
            ram_we    = addr_in && !word_bad;
            ram_waddr = addr_reg[AW-1:0];
        end
        else if (cmd.exec && opnd_in)
        begin
            if (grp == 4'd1 && minor_reg == 4'd0)
            begin
                ram_we = 1'b1;
            end
            else if (grp == 4'd2 && minor_reg == 4'd1)
            begin
                ram_we    = 1'b1;
                ram_wdata = acc_reg;
            end
        end
        if (cmd.fetch)
        begin
            ram_re    = 1'b1;
            ram_raddr = pc_reg[AW-1:0];
        end
        else if (cmd.op_read)
        begin
            ram_re = opnd_in;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            acc_reg     <= '0;
            stop_reg    <= 1'b0;
            clr_cnt_reg <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.quick)
            begin
                if (cmd_reg == CMD_EXEC && !stop_reg)
                begin
                    stop_reg <= 1'b1;
                end
                else if (cmd_reg == CMD_RESTART)
                begin
                    pc_reg   <= '0;
                    acc_reg  <= '0;
                    stop_reg <= 1'b0;
                end
            end
            if (cmd.exec)
            begin
                case (grp)
                    4'd2:
                    begin
                        if (minor_reg == 4'd0)
                        begin
                            acc_reg <= m_val;
                        end
                        pc_reg <= pc_inc;
                    end
                    4'd3:
                    begin
                        if (div_op && m_val == '0)
                        begin
                            stop_reg <= 1'b1;
                            pc_reg   <= pc_inc;
                        end
                    end
                    4'd4:
                    begin
                        case (minor_reg)
                            4'd0: pc_reg <= opnd_reg;
                            4'd1: pc_reg <= acc_reg[17] ? opnd_reg : pc_inc;
                            4'd2: pc_reg <= (acc_reg == '0) ? opnd_reg : pc_inc;
                            4'd3: stop_reg <= 1'b1;
                            default: pc_reg <= pc_inc;
                        endcase
                    end
                    default:
                    begin
                        pc_reg <= pc_inc;
                    end
                endcase
            end
            if (cmd.acc_commit)
            begin
                pc_reg <= pc_inc;
                if (fin_ovf)
                begin
                    stop_reg <= 1'b1;
                end
                else
                begin
                    acc_reg <= fin_r[17:0];
                end
            end
            if (cmd.push)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg  <= item_cmd;
            addr_reg <= item_address;
            val_reg  <= item_value;
        end
        if (cmd.decode)
        begin
            mag_reg  <= dec_mag;
            prod_reg <= prod_next;
            neg_reg  <= dec_src[17];
        end
        if (cmd.split)
        begin
            major_reg <= major_next;
            minor_reg <= minor_next;
            opnd_reg  <= opnd_next;
        end
        if (cmd.quick)
        begin
            pend_wv_reg   <= 1'b0;
            pend_wval_reg <= '0;
            if (cmd_reg == CMD_EXEC)
            begin
                pend_status_reg <= stop_reg ? ST_STOPPED : ST_PC_END;
            end
            else
            begin
                pend_status_reg <= ST_OK;
            end
        end
        if (cmd.ld_commit)
        begin
            pend_wv_reg     <= 1'b0;
            pend_wval_reg   <= '0;
            pend_status_reg <= (addr_in && !word_bad) ? ST_OK : ST_REJECT;
        end
        if (cmd.exec)
        begin
            pend_wv_reg   <= (grp == 4'd1) && (minor_reg == 4'd1);
            pend_wval_reg <= ((grp == 4'd1) && (minor_reg == 4'd1)) ? m_val : '0;
            div_mode_reg  <= (grp == 4'd3) && div_op;
            if ((grp == 4'd3) && div_op && (m_val == '0))
            begin
                pend_status_reg <= ST_DIV_ZERO;
            end
            else if ((grp == 4'd4) && (minor_reg == 4'd3))
            begin
                pend_status_reg <= ST_HALTED;
            end
            else
            begin
                pend_status_reg <= ST_OK;
            end
            case (minor_reg)
                4'd0: res_reg <= 37'(acc_reg) + 37'(m_val);
                4'd1: res_reg <= 37'(acc_reg) - 37'(m_val);
                4'd3: res_reg <= 37'(acc_reg * m_val);
                default: res_reg <= 37'(acc_reg);
            endcase
            div_q_reg   <= acc_mag;
            div_rem_reg <= '0;
            div_d_reg   <= m_mag;
            div_cnt_reg <= DIV_STEPS;
            div_sa_reg  <= acc_reg[17];
            div_sq_reg  <= acc_reg[17] ^ m_val[17];
        end
        if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - 5'd1;
            if (!rem_diff[18])
            begin
                div_rem_reg <= rem_diff;
                div_q_reg   <= {div_q_reg[16:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= rem_sh;
                div_q_reg   <= {div_q_reg[16:0], 1'b0};
            end
        end
        if (cmd.acc_commit && fin_ovf)
        begin
            pend_status_reg <= ST_OVERFLOW;
        end
        if (cmd.push)
        begin
            o_status_reg <= pend_status_reg;
            o_pc_reg     <= pc_reg;
            o_acc_reg    <= acc_reg;
            o_wv_reg     <= pend_wv_reg;
            o_wval_reg   <= pend_wval_reg;
        end
    end

    assign sts.clr_last  = (clr_cnt_reg == AW'(MEM_WORDS - 1));
    assign sts.is_load   = (cmd_reg == CMD_LOAD);
    assign sts.go_fetch  = (cmd_reg == CMD_EXEC) && !stop_reg && pc_in;
    assign sts.to_div    = (grp == 4'd3) && div_op && (m_val != '0);
    assign sts.to_acc    = (grp == 4'd3) && !div_op;
    assign sts.div_done  = (div_cnt_reg == 5'd0);
    assign sts.slot_free = !o_valid_reg || res_ready;

    assign res_valid     = o_valid_reg;
    assign res_status    = o_status_reg;
    assign res_pc        = o_pc_reg;
    assign res_acc_value = o_acc_reg;
    assign res_out_valid = o_wv_reg;
    assign res_out_value = o_wval_reg;
endmodule

// ===== rtl/decimal_accumulator_cpu_step.sv =====
`timescale 1ns / 1ps
// From accept to result: restart, stop and pc checks take a short path, a load is
// decoded, split and committed, and other words are fetched, decoded, split, read and
// executed; group 3 add, subtract and multiply then commit the accumulator, and divide
// and modulus pass through the one-bit-per-cycle divider before that commit.
// One word is in flight at a time: a new word is taken only after the last result is pushed.
// After reset a clearing pass writes zero to every memory word, with ready held low.
// ----------------------------------------------------------------------------
// decimal_accumulator_cpu_step : decimal accumulator machine
// Loads words, executes one instruction per command and restarts on request.
// ----------------------------------------------------------------------------
module decimal_accumulator_cpu_step #(
    parameter int MEM_WORDS = 1000
) (
    input  logic         clk,
    input  logic         rst_n,
    dac_item_if.sink     item,
    dac_result_if.source result
);
    import dac_pkg::*;

    dac_cmd_t cmd;
    dac_sts_t sts;

    dac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dac_datapath #(.MEM_WORDS(MEM_WORDS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .item_cmd      (item.cmd),
        .item_address  (item.address),
        .item_value    (item.value),
        .res_valid     (result.valid),
        .res_ready     (result.ready),
        .res_status    (result.status),
        .res_pc        (result.pc),
        .res_acc_value (result.acc_value),
        .res_out_valid (result.out_valid),
        .res_out_value (result.out_value)
    );
endmodule

// ===== rtl/dac_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_checker : port-level checks
// Watches the item and result channels of the top level over time.
// ----------------------------------------------------------------------------
module dac_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  res_status,
    input logic        res_wv,
    input logic [17:0] res_wval
);
    import dac_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_wval))
        else $error("stalled result word changed");

    // no write output without a write
    a_wv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_wv |-> res_wval == 18'd0)
        else $error("write value without write");

    // only an executed ok instruction shows a write
    a_wv_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_wv |-> res_status == ST_OK)
        else $error("write output with error status");

    // one word at a time: no accept in the cycle after an accept
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word accepted while busy");
endmodule

bind decimal_accumulator_cpu_step dac_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_status (result.status),
    .res_wv     (result.out_valid),
    .res_wval   (result.out_value)
);

// ===== dv/tb_decimal_accumulator_cpu_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_accumulator_cpu_step : decimal accumulator machine testbench
// Drives load, execute, restart and spare command words with random idling on both sides,
// predicts every result word from a behavioural copy of the machine and
// compares each field in order of arrival.
// ----------------------------------------------------------------------------
module tb_decimal_accumulator_cpu_step;
    import dac_pkg::*;

    localparam int MEM_WORDS = 1000;
    localparam int OVF_LIMIT = 9999;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [1:0] cmd;
        logic [9:0] address;
        word_t      value;
    } item_t;

    typedef struct {
        logic [2:0] status;
        logic [9:0] pc;
        word_t      acc_value;
        logic       out_valid;
        word_t      out_value;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dac_item_if   item_ch();
    dac_result_if result_ch();

    decimal_accumulator_cpu_step #(.MEM_WORDS(MEM_WORDS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    always #4 clk = ~clk;

    // machine copy
    int         mach_mem [MEM_WORDS];
    int         mach_pc;
    int         mach_acc;
    bit         mach_stopped;

    item_t      pending_words[$];
    result_t    awaited_results[$];
    int         mismatch_count = 0;
    bit         quiet_phase = 0;
    bit         stim_done = 0;

    function automatic bit word_rejected(int w);
        int major;
        int minor;
        major = w / 10000;
        minor = (w / 1000) % 10;
        if (major < 1 || major > 4) return 1;
        if (minor < 0) return 1;
        if ((major == 1 || major == 2) && minor > 1) return 1;
        if (major == 3 && minor > 4) return 1;
        if (major == 4 && minor > 3) return 1;
        return 0;
    endfunction

    function automatic int mem_rd(int a);
        if (a < 0 || a >= MEM_WORDS) return 0;
        return mach_mem[a];
    endfunction

    function automatic void mem_wr(int a, int v);
        if (a >= 0 && a < MEM_WORDS) mach_mem[a] = v;
    endfunction

    function automatic logic [2:0] run_instruction(int in_val, ref logic wv, ref int wval);
        int     w;
        int     major;
        int     minor;
        int     opnd;
        int     next;
        longint a;
        longint m;
        longint r;
        if (mach_stopped) return ST_STOPPED;
        if (mach_pc >= MEM_WORDS)
        begin
            mach_stopped = 1;
            return ST_PC_END;
        end
        w = mach_mem[mach_pc];
        major = w / 10000;
        minor = (w / 1000) % 10;
        opnd = w % 1000;
        next = mach_pc + 1;
        if (major == 1)
        begin
            if (minor == 0) mem_wr(opnd, in_val);
            else if (minor == 1)
            begin
                wv = 1;
                wval = mem_rd(opnd);
            end
        end
        else if (major == 2)
        begin
            if (minor == 0) mach_acc = mem_rd(opnd);
            else if (minor == 1) mem_wr(opnd, mach_acc);
        end
        else if (major == 3)
        begin
            a = mach_acc;
            m = mem_rd(opnd);
            r = a;
            if (minor == 0) r = a + m;
            else if (minor == 1) r = a - m;
            else if (minor == 2 || minor == 4)
            begin
                if (m == 0)
                begin
                    mach_stopped = 1;
                    mach_pc = next;
                    return ST_DIV_ZERO;
                end
                r = (minor == 2) ? a / m : a % m;
            end
            else if (minor == 3) r = a * m;
            if (r <= -OVF_LIMIT || r >= OVF_LIMIT)
            begin
                mach_stopped = 1;
                mach_pc = next;
                return ST_OVERFLOW;
            end
            mach_acc = int'(r);
        end
        else if (major == 4)
        begin
            if (minor == 0) next = opnd;
            else if (minor == 1) begin if (mach_acc < 0) next = opnd; end
            else if (minor == 2) begin if (mach_acc == 0) next = opnd; end
            else if (minor == 3)
            begin
                mach_stopped = 1;
                return ST_HALTED;
            end
        end
        mach_pc = next;
        return ST_OK;
    endfunction

    function automatic result_t predict_word(item_t it);
        result_t res;
        logic    wv;
        int      wval;
        int      val;
        wv = 0;
        wval = 0;
        val = int'(it.value);
        res.status = ST_OK;
        if (it.cmd == CMD_LOAD)
        begin
            if (it.address >= MEM_WORDS || word_rejected(val)) res.status = ST_REJECT;
            else mach_mem[it.address] = val;
        end
        else if (it.cmd == CMD_EXEC)
            res.status = run_instruction(val, wv, wval);
        else if (it.cmd == CMD_RESTART)
        begin
            mach_pc = 0;
            mach_acc = 0;
            mach_stopped = 0;
        end
        res.pc = mach_pc[9:0];
        res.acc_value = word_t'(mach_acc);
        res.out_valid = wv;
        res.out_value = wv ? word_t'(wval) : '0;
        return res;
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid   <= 1'b0;
            item_ch.cmd     <= '0;
            item_ch.address <= '0;
            item_ch.value   <= '0;
        end
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                item_ch.valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                item_t it;
                it = pending_words.pop_front();
                awaited_results.push_back(predict_word(it));
                item_ch.valid   <= 1'b1;
                item_ch.cmd     <= it.cmd;
                item_ch.address <= it.address;
                item_ch.value   <= it.value;
                if (!quiet_phase && $urandom_range(0, 9) == 0)
                    send_gap <= $urandom_range(1, 16);
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // monitor; hold ready low in random bursts
    int sink_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                result_t exp_r;
                if (awaited_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: status %0d pc %0d",
                                 result_ch.status, result_ch.pc);
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    if (result_ch.status !== exp_r.status || result_ch.pc !== exp_r.pc ||
                        result_ch.acc_value !== exp_r.acc_value ||
                        result_ch.out_valid !== exp_r.out_valid ||
                        result_ch.out_value !== exp_r.out_value)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: exp st %0d pc %0d acc %0d ov %0b out %0d",
                                      " / got st %0d pc %0d acc %0d ov %0b out %0d"},
                                     exp_r.status, exp_r.pc, exp_r.acc_value, exp_r.out_valid,
                                     exp_r.out_value, result_ch.status, result_ch.pc,
                                     result_ch.acc_value, result_ch.out_valid,
                                     result_ch.out_value);
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                result_ch.ready <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 11) == 0)
            begin
                sink_gap <= $urandom_range(0, 15);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    function automatic item_t mk(logic [1:0] c, int a, int v);
        item_t it;
        it.cmd = c;
        it.address = a[9:0];
        it.value = word_t'(v);
        return it;
    endfunction

    function automatic int rand_instr(int base_addr);
        int pick;
        int opnd;
        opnd = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 999)
                                             : base_addr + 20 + $urandom_range(0, 9);
        pick = $urandom_range(0, 13);
        case (pick)
            0:  return 10000 + opnd;
            1:  return 11000 + opnd;
            2:  return 20000 + opnd;
            3:  return 21000 + opnd;
            4:  return 30000 + opnd;
            5:  return 31000 + opnd;
            6:  return 32000 + opnd;
            7:  return 33000 + opnd;
            8:  return 34000 + opnd;
            9:  return 40000 + base_addr + $urandom_range(0, 12);
            10: return 41000 + base_addr + $urandom_range(0, 12);
            11: return 42000 + base_addr + $urandom_range(0, 12);
            12: return 43000;
            default: return 30000 + opnd;
        endcase
    endfunction

    // small programs: code at base, data at base+20
    task automatic add_program();
        int base;
        int n;
        base = $urandom_range(0, 40) * 30;
        if (base > 960) base = 960;
        for (int i = 0; i < 10; i++)
            pending_words.push_back(mk(CMD_LOAD, base + 20 + i,
                                       ($urandom_range(0, 1) ? 1 : -1) *
                                       (10000 + $urandom_range(0, 34999))));
        n = $urandom_range(3, 12);
        for (int i = 0; i < n; i++)
            pending_words.push_back(mk(CMD_LOAD, base + i, rand_instr(base)));
        pending_words.push_back(mk(CMD_RESTART, 0, 0));
        // jump to the program from address zero
        pending_words.push_back(mk(CMD_LOAD, 0, 40000 + base));
        n = $urandom_range(4, 25);
        for (int i = 0; i < n; i++)
            pending_words.push_back(mk(CMD_EXEC, 0, $urandom_range(0, 19996) - 9998));
    endtask

    initial
    begin
        int v;
        for (int i = 0; i < MEM_WORDS; i++) mach_mem[i] = 0;
        mach_pc = 0;
        mach_acc = 0;
        mach_stopped = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: rejects, extremes, arithmetic cases, halt, past end
        pending_words.push_back(mk(CMD_LOAD, 5, 99999));
        pending_words.push_back(mk(CMD_LOAD, 5, -99999));
        pending_words.push_back(mk(CMD_LOAD, 5, 12000));
        pending_words.push_back(mk(CMD_LOAD, 1023, 10000));
        pending_words.push_back(mk(CMD_LOAD, 999, 43000));
        pending_words.push_back(mk(CMD_SPARE, 0, 0));
        pending_words.push_back(mk(CMD_LOAD, 0, 20010));
        pending_words.push_back(mk(CMD_LOAD, 1, 32011));
        pending_words.push_back(mk(CMD_LOAD, 2, 33010));
        pending_words.push_back(mk(CMD_LOAD, 3, 11010));
        pending_words.push_back(mk(CMD_LOAD, 10, 19000));
        pending_words.push_back(mk(CMD_EXEC, 0, 0));
        pending_words.push_back(mk(CMD_EXEC, 0, 0));
        pending_words.push_back(mk(CMD_EXEC, 0, 0));
        pending_words.push_back(mk(CMD_RESTART, 0, 0));
        pending_words.push_back(mk(CMD_LOAD, 11, 1000));
        pending_words.push_back(mk(CMD_LOAD, 1, 34011));
        pending_words.push_back(mk(CMD_LOAD, 2, 11010));
        pending_words.push_back(mk(CMD_LOAD, 3, 40999));
        for (int i = 0; i < 6; i++) pending_words.push_back(mk(CMD_EXEC, 0, 0));

        quiet_phase = 0;
        while (pending_words.size() + 0 < 1100 && $urandom_range(0, 1) < 2)
        begin
            if (awaited_results.size() == 0 && pending_words.size() == 0)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // noise: any field values at all
                    for (int i = 0; i < 8; i++)
                    begin
                        v = $urandom_range(0, 262143);
                        pending_words.push_back(mk(2'($urandom_range(0, 3)),
                                                   $urandom_range(0, 1023),
                                                   v - (v >= 131072 ? 262144 : 0)));
                    end
                end
                else
                    add_program();
            end
            @(posedge clk);
            if (stim_count() >= 1000) quiet_phase = 1;
            if (stim_count() >= 1100) break;
        end
        wait (pending_words.size() == 0 && awaited_results.size() == 0);
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("tb_decimal_accumulator_cpu_step OK");
        else
            $display("tb_decimal_accumulator_cpu_step NOT OK");
        $finish;
    end

    // accepted input words
    int accepted_words = 0;
    always @(posedge clk)
        if (item_ch.valid && item_ch.ready) accepted_words <= accepted_words + 1;

    function automatic int stim_count();
        return accepted_words;
    endfunction

    initial
    begin
        #2_000_000;
        $display("tb_decimal_accumulator_cpu_step NOT OK");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/dac_pkg.sv
rtl/dac_item_if.sv
rtl/dac_result_if.sv
rtl/dac_ram.sv
rtl/dac_ctrl.sv
rtl/dac_datapath.sv
rtl/decimal_accumulator_cpu_step.sv
rtl/dac_checker.sv
dv/tb_decimal_accumulator_cpu_step.sv
